/* rtl/compressed_update_negotiation_filter_assert.svh */
// Assertion macros for the compressed update negotiation filter.
`ifndef COMPRESSED_UPDATE_NEGOTIATION_FILTER_ASSERT_SVH
`define COMPRESSED_UPDATE_NEGOTIATION_FILTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CUNF_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cunf check failed");

// next-cycle implication, sampled on clk, off during reset
`define CUNF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cunf check failed");

`endif

/* rtl/cunf_pkg.sv */
// Shared types, constants and CRC function of the negotiation filter.
package cunf_pkg;

	localparam logic [1:0] FUNC_RX    = 2'd0;
	localparam logic [1:0] FUNC_TX    = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	localparam logic [1:0] KIND_CMD   = 2'd0;
	localparam logic [1:0] KIND_NOTE  = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] CMD_START = 16'h0001;
	localparam logic [15:0] CMD_ACK   = 16'h0003;
	localparam logic [15:0] STATUS_OK = 16'h0000;
	localparam logic [7:0]  FLAG_SEL  = 8'h01;

	localparam logic [4:0] POS_LAST  = 5'd19;
	localparam logic [4:0] POS_OVER  = 5'd20;
	localparam logic [4:0] POS_HOLD  = 5'd13;
	localparam logic [4:0] POS_HDR   = 5'd6;
	localparam logic [4:0] POS_MAX   = 5'd31;
	localparam logic [4:0] POS_CMD   = 5'd2;
	localparam logic [4:0] POS_IMG   = 5'd6;
	localparam logic [4:0] POS_RESV  = 5'd10;
	localparam logic [4:0] POS_MAGIC = 5'd14;
	localparam logic [4:0] POS_CSIZE = 5'd18;

	localparam int HOLD_N = 7;

	localparam logic [2:0] IDX_MAGIC_END = 3'd3;
	localparam logic [2:0] IDX_FLAG      = 3'd4;
	localparam logic [2:0] IDX_CRC_LO    = 3'd5;
	localparam logic [2:0] IDX_CRC_HI    = 3'd6;
	localparam logic [2:0] IDX_FULL      = 3'd7;

	localparam int JOB_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 2;

	typedef struct packed {
		logic [1:0]       kind;
		logic             rewrite;
		logic [2:0]       cnt_m1;
		logic [7:0][7:0]  data;
		logic             last;
		logic [15:0]      crc;
		logic             sel;
		logic [31:0]      size;
	} job_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  out_byte;
		logic        out_last;
		logic        selected;
		logic [31:0] xfer_size;
	} res_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] i);
		logic [7:0] r;
		case (i)
			2'd0: r = 8'h4D;
			2'd1: r = 8'h35;
			2'd2: r = 8'h5A;
			default: r = 8'h31;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

/* rtl/cunf_fifo.sv */
// Small register queue used between front, back and the result port.
module cunf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = cnt_q == FULL_CNT;
	assign empty   = cnt_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/cunf_front.sv */
// Front end: packet tracking, START check, size store and job building.
module cunf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc,
	input  logic [1:0]         func,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	input  logic [31:0]        query_image_size,
	output logic               job_vld,
	output cunf_pkg::job_t     job
);
	logic [31:0] neg_q, neg_d;
	logic [4:0]  rx_pos_q, rx_pos_d;
	logic [15:0] rx_cmd_q, rx_cmd_d;
	logic [31:0] rx_img_q, rx_img_d;
	logic        rx_resv_nz_q, rx_resv_nz_d;
	logic        rx_magic_q, rx_magic_d;
	logic [31:0] rx_csize_q, rx_csize_d;
	logic [4:0]  tx_pos_q, tx_pos_d;
	logic [47:0] tx_hdr_q, tx_hdr_d;
	logic [15:0] tx_crc_q, tx_crc_d;
	logic [7:0]  held_q [cunf_pkg::HOLD_N];
	logic        held_we;
	logic [2:0]  hold_idx;
	logic [1:0]  off;
	logic        ack_match;
	logic        rx_ok;

	assign off      = rx_pos_q[1:0] - 2'd2;
	assign hold_idx = 3'(tx_pos_q - cunf_pkg::POS_HOLD);

	always_comb begin
		neg_d        = neg_q;
		rx_pos_d     = rx_pos_q;
		rx_cmd_d     = rx_cmd_q;
		rx_img_d     = rx_img_q;
		rx_resv_nz_d = rx_resv_nz_q;
		rx_magic_d   = rx_magic_q;
		rx_csize_d   = rx_csize_q;
		tx_pos_d     = tx_pos_q;
		tx_hdr_d     = tx_hdr_q;
		tx_crc_d     = tx_crc_q;
		held_we      = 1'b0;
		job_vld      = 1'b0;
		job          = '0;
		ack_match    = 1'b0;
		rx_ok        = 1'b0;
		case (func)
			cunf_pkg::FUNC_RX: begin
				job_vld     = acc;
				job.kind    = cunf_pkg::KIND_CMD;
				job.data[0] = in_byte;
				job.last    = in_last;
				if (rx_pos_q < cunf_pkg::POS_CMD) begin
					rx_cmd_d[{rx_pos_q[0], 3'b000} +: 8] = in_byte;
				end else if (rx_pos_q < cunf_pkg::POS_IMG) begin
					rx_img_d[{off, 3'b000} +: 8] = in_byte;
				end else if (rx_pos_q < cunf_pkg::POS_RESV) begin
					rx_resv_nz_d = rx_resv_nz_q || (in_byte != 8'h00);
				end else if (rx_pos_q < cunf_pkg::POS_MAGIC) begin
					rx_magic_d = rx_magic_q && (in_byte == cunf_pkg::magic_byte(off));
				end else if (rx_pos_q < cunf_pkg::POS_CSIZE) begin
					rx_csize_d[{off, 3'b000} +: 8] = in_byte;
				end
				rx_ok = !rx_resv_nz_q && rx_magic_q && (rx_csize_q != '0) &&
					(rx_csize_q < rx_img_q);
				if (in_last) begin
					if (rx_pos_q == cunf_pkg::POS_LAST && rx_cmd_q == cunf_pkg::CMD_START) begin
						neg_d = rx_ok ? rx_csize_q : '0;
					end
					rx_pos_d     = '0;
					rx_cmd_d     = '0;
					rx_img_d     = '0;
					rx_resv_nz_d = 1'b0;
					rx_magic_d   = 1'b1;
					rx_csize_d   = '0;
				end else if (rx_pos_q != cunf_pkg::POS_MAX) begin
					rx_pos_d = rx_pos_q + 1'b1;
				end
			end
			cunf_pkg::FUNC_TX: begin
				job.kind = cunf_pkg::KIND_NOTE;
				if (tx_pos_q < cunf_pkg::POS_HOLD) begin
					job_vld     = acc;
					job.data[0] = in_byte;
					job.last    = in_last;
					if (tx_pos_q < cunf_pkg::POS_HDR) begin
						tx_hdr_d[{tx_pos_q[2:0], 3'b000} +: 8] = in_byte;
					end
					tx_crc_d = cunf_pkg::crc_byte(tx_crc_q, in_byte);
				end else if (tx_pos_q < cunf_pkg::POS_OVER) begin
					held_we = acc;
					if (in_last) begin
						job_vld   = acc;
						job.last  = 1'b1;
						ack_match = tx_pos_q == cunf_pkg::POS_LAST &&
							tx_hdr_q[15:0] == cunf_pkg::CMD_ACK &&
							tx_hdr_q[31:16] == cunf_pkg::CMD_START;
						if (ack_match && tx_hdr_q[47:32] == cunf_pkg::STATUS_OK &&
							neg_q != '0) begin
							job.rewrite = 1'b1;
							job.cnt_m1  = cunf_pkg::IDX_CRC_HI;
							job.crc     = tx_crc_q;
						end else begin
							for (int i = 0; i < cunf_pkg::HOLD_N; i++) begin
								job.data[i] = held_q[i];
							end
							job.data[hold_idx] = in_byte;
							job.cnt_m1         = hold_idx;
						end
						if (ack_match) begin
							neg_d = '0;
						end
					end
				end else begin
					job_vld  = acc;
					job.last = in_last;
					if (tx_pos_q == cunf_pkg::POS_OVER) begin
						for (int i = 0; i < cunf_pkg::HOLD_N; i++) begin
							job.data[i] = held_q[i];
						end
						job.data[cunf_pkg::IDX_FULL] = in_byte;
						job.cnt_m1                   = cunf_pkg::IDX_FULL;
					end else begin
						job.data[0] = in_byte;
					end
				end
				if (in_last) begin
					tx_pos_d = '0;
					tx_hdr_d = '0;
					tx_crc_d = '0;
				end else if (tx_pos_q != cunf_pkg::POS_MAX) begin
					tx_pos_d = tx_pos_q + 1'b1;
				end
			end
			cunf_pkg::FUNC_QUERY: begin
				job_vld  = acc;
				job.kind = cunf_pkg::KIND_QUERY;
				job.sel  = (neg_q != '0) && (neg_q < query_image_size);
				job.size = job.sel ? neg_q : '0;
			end
			default: begin
				job_vld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (held_we) begin
			held_q[hold_idx] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q        <= '0;
			rx_pos_q     <= '0;
			rx_cmd_q     <= '0;
			rx_img_q     <= '0;
			rx_resv_nz_q <= 1'b0;
			rx_magic_q   <= 1'b1;
			rx_csize_q   <= '0;
			tx_pos_q     <= '0;
			tx_hdr_q     <= '0;
			tx_crc_q     <= '0;
		end else if (acc) begin
			neg_q        <= neg_d;
			rx_pos_q     <= rx_pos_d;
			rx_cmd_q     <= rx_cmd_d;
			rx_img_q     <= rx_img_d;
			rx_resv_nz_q <= rx_resv_nz_d;
			rx_magic_q   <= rx_magic_d;
			rx_csize_q   <= rx_csize_d;
			tx_pos_q     <= tx_pos_d;
			tx_hdr_q     <= tx_hdr_d;
			tx_crc_q     <= tx_crc_d;
		end
	end

endmodule

/* rtl/cunf_back.sv */
// Back end: expands one job into result words, one per cycle while the result queue has room.
module cunf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  cunf_pkg::job_t  job,
	input  logic            job_empty,
	output logic            job_pop,
	input  logic            res_full,
	output logic            res_push,
	output cunf_pkg::res_t  res
);
	logic [2:0]  idx_q;
	logic [15:0] crc_q;
	logic [15:0] crc_cur;
	logic [7:0]  byte_cur;
	logic        at_end;

	assign res_push = !job_empty && !res_full;
	assign at_end   = idx_q == job.cnt_m1;
	assign job_pop  = res_push && at_end;
	assign crc_cur  = (idx_q == '0) ? job.crc : crc_q;

	always_comb begin
		if (job.rewrite) begin
			if (idx_q <= cunf_pkg::IDX_MAGIC_END) begin
				byte_cur = cunf_pkg::magic_byte(idx_q[1:0]);
			end else begin
				case (idx_q)
					cunf_pkg::IDX_FLAG:   byte_cur = cunf_pkg::FLAG_SEL;
					cunf_pkg::IDX_CRC_LO: byte_cur = crc_cur[7:0];
					cunf_pkg::IDX_CRC_HI: byte_cur = crc_cur[15:8];
					default:              byte_cur = 8'h00;
				endcase
			end
		end else begin
			byte_cur = job.data[idx_q];
		end
		res.kind      = job.kind;
		res.out_byte  = byte_cur;
		res.out_last  = job.last && at_end;
		res.selected  = job.sel;
		res.xfer_size = job.size;
	end

	// advance the CRC over magic and flag only; hold it for both CRC bytes
	always_ff @(posedge clk) begin
		if (res_push && idx_q <= cunf_pkg::IDX_FLAG) begin
			crc_q <= cunf_pkg::crc_byte(crc_cur, byte_cur);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (res_push) begin
			idx_q <= at_end ? '0 : idx_q + 1'b1;
		end
	end

endmodule

/* rtl/compressed_update_negotiation_filter.sv */
// Top level of the compressed update negotiation filter.
// Input channel: push/full. A word carries func, in_byte, in_last and
// query_image_size; it is taken at a clock edge with push high and full low.
// Output channel: empty/pop. While empty is low the oldest result word is on
// kind, out_byte, out_last, selected and xfer_size; pop takes it.
// The front end takes one input word per cycle while full is low, tracks both
// packet streams, keeps the negotiated size and turns each RX, TX or query word
// into a job in a job queue (JOB_DEPTH deep), or holds a TX byte for a later
// job. The back end writes the result words of each job, one per cycle while
// the result queue (OUT_DEPTH deep) has room; the head of the result queue
// drives the output ports.
// Throughput: one input word per cycle while the job queue has room; one
// result word per cycle while the result queue has room, so a held-byte flush or
// a rewritten acknowledgement (up to 8 words) holds the back end until done.
// When the receiver stalls the result queue fills, then the job queue, then
// full rises; nothing is dropped.
// Reset clears both queues, the packet positions and the negotiated size.
module compressed_update_negotiation_filter #(
	parameter int JOB_DEPTH = cunf_pkg::JOB_DEPTH_DEF,
	parameter int OUT_DEPTH = cunf_pkg::OUT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  logic [31:0] query_image_size,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic        selected,
	output logic [31:0] xfer_size
);
	`include "compressed_update_negotiation_filter_assert.svh"

	logic           acc;
	logic           job_vld;
	cunf_pkg::job_t job_in;
	cunf_pkg::job_t job_head;
	logic           job_full;
	logic           job_empty;
	logic           job_pop;
	logic           res_full;
	logic           res_push;
	cunf_pkg::res_t res_in;
	cunf_pkg::res_t res_head;

	assign full = job_full;
	assign acc  = push && !job_full;

	cunf_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.acc              (acc),
		.func             (func),
		.in_byte          (in_byte),
		.in_last          (in_last),
		.query_image_size (query_image_size),
		.job_vld          (job_vld),
		.job              (job_in)
	);

	cunf_fifo #(
		.WIDTH ($bits(cunf_pkg::job_t)),
		.DEPTH (JOB_DEPTH)
	) u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_vld),
		.wr_data (job_in),
		.rd_en   (job_pop),
		.rd_data (job_head),
		.full    (job_full),
		.empty   (job_empty)
	);

	cunf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_head),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	cunf_fifo #(
		.WIDTH ($bits(cunf_pkg::res_t)),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.rd_en   (pop),
		.rd_data (res_head),
		.full    (res_full),
		.empty   (empty)
	);

	assign kind      = res_head.kind;
	assign out_byte  = res_head.out_byte;
	assign out_last  = res_head.out_last;
	assign selected  = res_head.selected;
	assign xfer_size = res_head.xfer_size;

	`CUNF_ASSERT_IMPLY(a_query_no_bytes, !empty && kind == cunf_pkg::KIND_QUERY, out_byte == 8'h00 && !out_last)
	`CUNF_ASSERT_IMPLY(a_fwd_no_answer, !empty && kind != cunf_pkg::KIND_QUERY, !selected && xfer_size == '0)
	`CUNF_ASSERT_IMPLY(a_sel_has_size, !empty && selected, xfer_size != '0)
	`CUNF_ASSERT_NEXT(a_query_queued, push && !full && func == cunf_pkg::FUNC_QUERY, !job_empty)

endmodule
